// File: hdl/lmad_pkg.sv
package lmad_pkg;

  localparam int RadiusDefault   = 5;
  localparam int MaxWidthDefault = 256;

  localparam int SampleW = 16;
  localparam int RowW    = 12;
  localparam int ColW    = 8;
  localparam int FwW     = 9;
  localparam int FhW     = 12;
  localparam int CfgIdxW = 1;

  localparam logic [FwW-1:0] FwReset = FwW'(200);
  localparam logic [FhW-1:0] FhReset = FhW'(200);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  // command codes
  localparam logic CmdSample = 1'b0;
  localparam logic CmdFlush  = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [SampleW-1:0] sample;
  } lmad_in_t;

  typedef struct packed {
    logic [RowW-1:0]    row_index;
    logic [ColW-1:0]    col_index;
    logic [SampleW-1:0] mean_abs_diff;
    logic               frame_last;
  } lmad_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [FhW-1:0]     data;
  } lmad_cfg_t;

endpackage

// File: hdl/lmad_if.sv
interface lmad_in_if;
  logic               valid;
  logic               ready;
  lmad_pkg::lmad_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lmad_out_if;
  logic                valid;
  logic                ready;
  lmad_pkg::lmad_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lmad_cfg_if;
  logic                valid;
  logic                ready;
  lmad_pkg::lmad_cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/local_mean_abs_diff_filter.sv
// Local mean absolute difference filter.
// in_ch : raster-order items, cmd=0 carries a sample, cmd=1 is a flush step.
// out_ch: zero or one result per input item: cell position, truncated mean of
//         |neighbour - centre| over the in-grid (2R+1)^2 window, frame_last.
// cfg_ch: index 0 = frame_width, 1 = frame_height; a write restarts the frame.
// Results lag the input by R rows plus R cells; flush items drain the tail.
// Steps per item: accept and store the sample, then check whether a cell
// is ready; then, for an item that completes a cell, read the centre, walk
// the (2R+1)^2 window through a single read port and one shared abs-diff
// accumulator, run a restoring divider (load plus 16 steps), and load the
// output register. Items with no result end after the check.
// The result sits in the output register until taken; the next item is
// accepted only once it has gone, so a stalled receiver stalls the input.
// Reset (rst_n low, synchronous) returns to the default 200 x 200 frame with
// all positions at zero. The line store is not cleared: every entry used has
// been written earlier in the frame.
module local_mean_abs_diff_filter #(
  parameter int RADIUS    = lmad_pkg::RadiusDefault,
  parameter int MAX_WIDTH = lmad_pkg::MaxWidthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  lmad_in_if.sink   in_ch,
  lmad_out_if.source out_ch,
  lmad_cfg_if.sink  cfg_ch
);
  import lmad_pkg::*;

  localparam int Side   = 2 * RADIUS + 1;
  localparam int Depth  = Side * MAX_WIDTH;
  localparam int AddrW  = $clog2(Depth);
  localparam int WinW   = $clog2(Side * Side + 1);
  localparam int SideW  = $clog2(Side + 1);
  localparam int SumW   = SampleW + WinW;
  localparam int LinW   = RowW + 13;
  localparam int DivIt  = SampleW;
  localparam int DivCntW = $clog2(DivIt + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_CTR   = 6'b000100,
    S_WIN   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [FwW-1:0] fw_r;
  logic [FhW-1:0] fh_r;
  logic [RowW:0]  in_row_r;   // one spare bit: reaches h
  logic [ColW:0]  in_col_r;
  logic [RowW-1:0] out_row_r;
  logic [ColW:0]   out_col_r;

  // effective sizes
  logic [FwW-1:0] w_eff;
  logic [FhW-1:0] h_eff;
  always_comb begin
    w_eff = fw_r;
    if (fw_r < FwW'(2)) w_eff = FwW'(2);
    if (32'(fw_r) > MAX_WIDTH) w_eff = FwW'(MAX_WIDTH);
    h_eff = (fh_r < FhW'(2)) ? FhW'(2) : fh_r;
  end

  logic [SampleW-1:0] mem [Depth];
  logic [SampleW-1:0] rd_data_r;

  // linear indexes (all rows < 4096, width <= 256)
  logic [LinW-1:0] total, lag, received, p_lin;
  logic in_done;
  assign total    = LinW'(h_eff) * LinW'(w_eff);
  assign lag      = LinW'(RADIUS) * LinW'(w_eff) + LinW'(RADIUS);
  assign in_done  = in_row_r >= (RowW+1)'(h_eff);
  assign received = in_done ? total : LinW'(in_row_r) * LinW'(w_eff) + LinW'(in_col_r);
  assign p_lin    = LinW'(out_row_r) * LinW'(w_eff) + LinW'(out_col_r);

  // store address, kept incrementally modulo Depth
  logic [AddrW-1:0] wr_addr_r;  // address of next input cell
  logic [AddrW-1:0] ctr_addr_r; // address of next output cell
  logic [AddrW-1:0] rd_addr;

  function automatic logic [AddrW-1:0] addr_add(input logic [AddrW-1:0] a,
                                                input logic signed [AddrW+1:0] d);
    logic signed [AddrW+2:0] s;
    begin
      s = $signed({3'b000, a}) + (AddrW+3)'(d);
      if (s < 0) s = s + (AddrW+3)'(Depth);
      else if (s >= (AddrW+3)'(Depth)) s = s - (AddrW+3)'(Depth);
      addr_add = s[AddrW-1:0];
    end
  endfunction

  // window walk
  logic [SideW-1:0] wi_r, wj_r;
  logic signed [RowW+1:0] rr;
  logic signed [ColW+1:0] cc;
  logic signed [AddrW+1:0] off;
  logic in_grid, rd_ok_r, is_ctr_r, last_rd_r;
  logic [SampleW-1:0] ctr_val_r;
  logic [SumW-1:0] sum_r;
  logic [WinW-1:0] cnt_r;

  assign rr  = $signed({2'b00, out_row_r}) + (RowW+2)'($signed({1'b0, wi_r}))
               - (RowW+2)'(RADIUS);
  assign cc  = $signed({1'b0, out_col_r}) + (ColW+2)'($signed({1'b0, wj_r}))
               - (ColW+2)'(RADIUS);
  assign off = (AddrW+2)'($signed({1'b0, wi_r}) - RADIUS) * $signed({1'b0, w_eff})
               + (AddrW+2)'($signed({1'b0, wj_r}) - RADIUS);
  assign in_grid = (rr >= 0) && (rr < $signed({2'b00, h_eff}))
                   && (cc >= 0) && (cc < $signed({1'b0, w_eff}));
  assign rd_addr = (state_r == S_CTR) ? ctr_addr_r : addr_add(ctr_addr_r, off);

  logic win_end;
  assign win_end = (wi_r == SideW'(Side-1)) && (wj_r == SideW'(Side-1));

  // divider
  logic [SumW-1:0] rem_r;
  logic [SampleW-1:0] quo_r;
  logic [DivCntW-1:0] dcnt_r;
  logic [SumW:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[SampleW-1]};

  logic in_acc, out_acc, cfg_acc, sample_wr;
  assign in_ch.ready  = (state_r == S_IDLE) && !out_ch.valid;
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign sample_wr = in_acc && (in_ch.payload.cmd == CmdSample) && !in_done;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CHECK;
      S_CHECK: begin
        if (p_lin < total && (in_done || received >= p_lin + lag + LinW'(1)))
          state_nxt = S_CTR;
        else
          state_nxt = S_IDLE;
      end
      S_CTR:   state_nxt = S_WIN;
      S_WIN:   if (last_rd_r) state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == DivCntW'(DivIt)) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // line store port
  always_ff @(posedge clk) begin
    if (sample_wr) mem[wr_addr_r] <= in_ch.payload.sample;
    rd_data_r <= mem[rd_addr];
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fw_r       <= FwReset;
      fh_r       <= FhReset;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      wr_addr_r  <= '0;
      ctr_addr_r <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) out_ch.valid <= 1'b0;
      if (cfg_acc) begin
        if (cfg_ch.payload.index == RegFrameWidth) fw_r <= cfg_ch.payload.data[FwW-1:0];
        else fh_r <= cfg_ch.payload.data;
        in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
        wr_addr_r <= '0; ctr_addr_r <= '0;
      end else begin
        if (sample_wr) begin
          wr_addr_r <= addr_add(wr_addr_r, (AddrW+2)'(1));
          if (in_col_r + (ColW+1)'(1) >= (ColW+1)'(w_eff)) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + (RowW+1)'(1);
          end else begin
            in_col_r <= in_col_r + (ColW+1)'(1);
          end
        end
        if (state_r == S_OUT) begin
          out_ch.valid <= 1'b1;
          if (p_lin == total - LinW'(1)) begin
            in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
            wr_addr_r <= '0; ctr_addr_r <= '0;
          end else begin
            ctr_addr_r <= addr_add(ctr_addr_r, (AddrW+2)'(1));
            if (out_col_r + (ColW+1)'(1) >= (ColW+1)'(w_eff)) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + RowW'(1);
            end else begin
              out_col_r <= out_col_r + (ColW+1)'(1);
            end
          end
        end
      end
    end
  end

  // window accumulation and division
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_CTR: begin
        wi_r <= '0; wj_r <= '0;
        sum_r <= '0; cnt_r <= '0;
        rd_ok_r <= 1'b0; is_ctr_r <= 1'b1; last_rd_r <= 1'b0;
      end
      S_WIN: begin
        if (is_ctr_r) ctr_val_r <= rd_data_r;
        else if (rd_ok_r) begin
          sum_r <= sum_r + SumW'((rd_data_r > ctr_val_r) ? rd_data_r - ctr_val_r
                                                           : ctr_val_r - rd_data_r);
          cnt_r <= cnt_r + WinW'(1);
        end
        is_ctr_r  <= 1'b0;
        rd_ok_r   <= in_grid && !(wi_r == SideW'(RADIUS) && wj_r == SideW'(RADIUS));
        last_rd_r <= win_end;
        if (wj_r == SideW'(Side-1)) begin
          wj_r <= '0;
          wi_r <= wi_r + SideW'(1);
        end else begin
          wj_r <= wj_r + SideW'(1);
        end
        if (last_rd_r) begin
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= '0;
        end
      end
      S_DIV: begin
        if (dcnt_r == '0) begin
          // load the sum as dividend; quotient fits in 16 bits
          rem_r  <= SumW'(sum_r >> SampleW);
          quo_r  <= sum_r[SampleW-1:0];
          dcnt_r <= DivCntW'(1);
        end else begin
          if (rem_sh >= (SumW+1)'(cnt_r)) begin
            rem_r <= SumW'(rem_sh - (SumW+1)'(cnt_r));
            quo_r <= {quo_r[SampleW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[SumW-1:0];
            quo_r <= {quo_r[SampleW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DivCntW'(1);
        end
      end
      S_OUT: begin
        out_ch.payload.row_index     <= out_row_r;
        out_ch.payload.col_index     <= out_col_r[ColW-1:0];
        out_ch.payload.mean_abs_diff <= (cnt_r == '0) ? '0 : quo_r;
        out_ch.payload.frame_last    <= (p_lin == total - LinW'(1));
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/lmad_checker.sv
module lmad_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [11:0] out_row,
  input logic [7:0]  out_col
);
  // no new item while a result is still held
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // held result keeps its row and column
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col))
    else $error("stalled result changed");

  // block is busy for the cycle after accepting an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");

  // frame end result is never on row zero (at least two rows)
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_row != 12'd0))
    else $error("frame_last on first row");
endmodule

bind local_mean_abs_diff_filter lmad_checker u_lmad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.payload.frame_last),
  .out_row   (out_ch.payload.row_index),
  .out_col   (out_ch.payload.col_index)
);

// File: bench/local_mean_abs_diff_filter_test.sv
`timescale 1ns / 1ps

module local_mean_abs_diff_filter_test;
  import lmad_pkg::*;

  localparam int Rad      = RadiusDefault;
  localparam int MaxW     = MaxWidthDefault;
  localparam int Depth    = (2 * Rad + 1) * MaxW;
  localparam int CycLimit = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lmad_in_if  in_ch ();
  lmad_out_if out_ch ();
  lmad_cfg_if cfg_ch ();

  local_mean_abs_diff_filter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [SampleW-1:0] grid_mem [Depth];
  logic [FwW-1:0] fw_reg;
  logic [FhW-1:0] fh_reg;
  int unsigned    nx_in_row, nx_in_col, nx_out_row, nx_out_col;

  lmad_in_t  pending_items [$];
  lmad_out_t expected_results [$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        cycle_count = 0;
  bit        stim_done = 1'b0;

  function automatic int unsigned cur_width();
    int unsigned w;
    w = fw_reg;
    if (w < 2) w = 2;
    if (w > MaxW) w = MaxW;
    return w;
  endfunction

  function automatic int unsigned cur_height();
    return (fh_reg < 2) ? 2 : fh_reg;
  endfunction

  function automatic void restart_frame();
    nx_in_row = 0; nx_in_col = 0; nx_out_row = 0; nx_out_col = 0;
  endfunction

  // work out the result (if any) caused by one accepted item
  function automatic void predict_cell(lmad_in_t it);
    int unsigned w, h, total, lag, rcvd, p, v, x, sum, cnt;
    bit in_done;
    int rr, cc;
    lmad_out_t res;
    w = cur_width();
    h = cur_height();
    total = w * h;
    lag = Rad * w + Rad;
    in_done = nx_in_row >= h;
    if (it.cmd == CmdSample && !in_done) begin
      grid_mem[(nx_in_row * w + nx_in_col) % Depth] = it.sample;
      nx_in_col++;
      if (nx_in_col >= w) begin
        nx_in_col = 0;
        nx_in_row++;
      end
      in_done = nx_in_row >= h;
    end
    rcvd = in_done ? total : nx_in_row * w + nx_in_col;
    p = nx_out_row * w + nx_out_col;
    if (p >= total) return;
    if (!in_done && rcvd < p + lag + 1) return;
    v = grid_mem[p % Depth];
    sum = 0;
    cnt = 0;
    for (int dr = -Rad; dr <= Rad; dr++) begin
      rr = int'(nx_out_row) + dr;
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dc = -Rad; dc <= Rad; dc++) begin
        cc = int'(nx_out_col) + dc;
        if (dr == 0 && dc == 0) continue;
        if (cc < 0 || cc >= int'(w)) continue;
        x = grid_mem[(rr * w + cc) % Depth];
        sum += (x > v) ? x - v : v - x;
        cnt++;
      end
    end
    res.row_index     = RowW'(nx_out_row);
    res.col_index     = ColW'(nx_out_col);
    res.mean_abs_diff = SampleW'(cnt != 0 ? sum / cnt : 0);
    res.frame_last    = (p == total - 1);
    expected_results.push_back(res);
    if (p == total - 1) restart_frame();
    else begin
      nx_out_col++;
      if (nx_out_col >= w) begin
        nx_out_col = 0;
        nx_out_row++;
      end
    end
  endfunction

  // driver: input channel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_cell(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= pending_items.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result channel
  always @(posedge clk) begin
    lmad_out_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_results.size() == 0) begin
          $error("unexpected result row %0d col %0d", got.row_index, got.col_index);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            errors++;
          end
          if (got.col_index !== want.col_index) begin
            $error("col_index: expected %0d, got %0d", want.col_index, got.col_index);
            errors++;
          end
          if (got.mean_abs_diff !== want.mean_abs_diff) begin
            $error("mean_abs_diff: expected %0d, got %0d",
                   want.mean_abs_diff, got.mean_abs_diff);
            errors++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycLimit) begin
      $display("local_mean_abs_diff_filter_test: done, errors");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [FhW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == RegFrameWidth) fw_reg = val[FwW-1:0];
    else fh_reg = val;
    restart_frame();
    @(posedge clk);
  endtask

  // one frame of random samples, optionally broken off early; then flushes
  task automatic queue_frame(int n_cells, int n_flush);
    lmad_in_t it;
    for (int i = 0; i < n_cells; i++) begin
      it.cmd = ($urandom_range(99) < 3) ? CmdFlush : CmdSample;
      case ($urandom_range(3))
        0: it.sample = 16'hFFFF;
        1: it.sample = 16'h0000;
        default: it.sample = 16'($urandom);
      endcase
      pending_items.push_back(it);
    end
    for (int i = 0; i < n_flush; i++) begin
      it.cmd = CmdFlush;
      it.sample = 16'($urandom);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    int w, h;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    fw_reg = FwReset;
    fh_reg = FhReset;
    restart_frame();
    for (int i = 0; i < Depth; i++) grid_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, clamped values, extremes, early flush
    write_reg(RegFrameWidth, 12'd0);
    write_reg(RegFrameHeight, 12'd1);
    pending_items.push_back('{cmd: CmdFlush, sample: 16'hFFFF});
    pending_items.push_back('{cmd: CmdSample, sample: 16'hFFFF});
    pending_items.push_back('{cmd: CmdSample, sample: 16'h0000});
    pending_items.push_back('{cmd: CmdSample, sample: 16'h8000});
    pending_items.push_back('{cmd: CmdSample, sample: 16'h7FFF});
    pending_items.push_back('{cmd: CmdFlush, sample: 16'h0});
    pending_items.push_back('{cmd: CmdSample, sample: 16'h1234});
    for (int i = 0; i < 4; i++)
      pending_items.push_back('{cmd: i[0] ? CmdSample : CmdFlush, sample: 16'h5555});
    drain();
    write_reg(RegFrameWidth, 12'h1FF);
    write_reg(RegFrameHeight, 12'd2);
    queue_frame(512, 0);
    queue_frame(20, 0);
    drain();

    // random phases: idle settings cycle through the four combinations
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      w = ($urandom_range(3) == 0) ? $urandom_range(2, 20) : $urandom_range(2, 8);
      h = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 6);
      if (ph == 5) w = 0;
      if (ph == 9) h = 12'hFFF;
      write_reg(RegFrameWidth, 12'(w));
      write_reg(RegFrameHeight, 12'(h));
      if (ph == 9) queue_frame(60, 2);
      else begin
        queue_frame(cur_width() * cur_height(), $urandom_range(0, 3) == 0 ? 3 :
                    Rad * cur_width() + Rad + 4);
        if ($urandom_range(1)) queue_frame($urandom_range(1, 30), $urandom_range(0, 5));
      end
      drain();
    end

    if (errors == 0 && expected_results.size() == 0)
      $display("local_mean_abs_diff_filter_test: done, clean");
    else
      $display("local_mean_abs_diff_filter_test: done, errors");
    $finish;
  end

endmodule
